@@ src/icc_pkg.sv @@
// Shared constants and types for the interval capacity check block.
package icc_pkg;

  localparam int MAX_TRIPS_DEF  = 64;
  localparam int POINT_BITS_DEF = 10;
  localparam int LOAD_BITS_DEF  = 8;
  localparam int CAP_BITS       = 16;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RDI,
    S_GETI,
    S_SCAN,
    S_CHK,
    S_DONE
  } icc_state_t;

  typedef struct packed {
    logic clear;
    logic en;
  } acc_ctl_t;

endpackage

@@ src/icc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module icc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/icc_acc.sv @@
// Shared accumulate-and-compare unit: sums the loads aboard when trip i boards.
module icc_acc
  import icc_pkg::*;
#(
  parameter int MAX_TRIPS  = MAX_TRIPS_DEF,
  parameter int POINT_BITS = POINT_BITS_DEF,
  parameter int LOAD_BITS  = LOAD_BITS_DEF
) (
  input  logic                         clk,
  input  acc_ctl_t                     ctl,
  input  logic [$clog2(MAX_TRIPS)-1:0] i_idx,
  input  logic [POINT_BITS-1:0]        i_pickup,
  input  logic [POINT_BITS-1:0]        i_dropoff,
  input  logic [$clog2(MAX_TRIPS)-1:0] j_idx,
  input  logic [LOAD_BITS-1:0]         j_load,
  input  logic [POINT_BITS-1:0]        j_pickup,
  input  logic [POINT_BITS-1:0]        j_dropoff,
  input  logic [CAP_BITS-1:0]          capacity,
  output logic                         over
);

  localparam int SW = LOAD_BITS + $clog2(MAX_TRIPS) + 1;
  localparam int CW = (SW > CAP_BITS) ? SW : CAP_BITS;

  logic [SW-1:0] acc_r;
  logic [SW-1:0] acc_nxt;
  logic          earlier;
  logic          counts;

  // Trip j is aboard when trip i boards if it sorts ahead of i and has not
  // yet been dropped off at i's pickup; trip i itself always counts.
  always_comb begin
    earlier = (j_pickup < i_pickup) ||
              ((j_pickup == i_pickup) &&
               ((j_dropoff < i_dropoff) ||
                ((j_dropoff == i_dropoff) && (j_idx < i_idx))));
    counts  = (j_idx == i_idx) || (earlier && (j_dropoff > i_pickup));
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.en && counts) begin
      acc_nxt = acc_r + SW'(j_load);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign over = CW'(acc_r) > CW'(capacity);

endmodule

@@ src/interval_capacity_check_top.sv @@
// Top level of the interval capacity check: trip loading, sequencer, result register.
//
// Usage. Trips arrive on the in_ channel, one word per trip (load, pickup,
// dropoff, last_trip). While loading, the block takes one word per cycle and
// writes it into the trip store. A trip that arrives when MAX_TRIPS trips are
// already stored is dropped and remembered as too_many_trips.
// When the word with last_trip set is taken, the block stalls its input and
// checks the set: for every stored trip i it streams all n stored trips
// through one shared accumulator, summing the loads of trips that sort ahead
// of i (by pickup, then dropoff, then arrival) and are still aboard at i's
// pickup, plus i's own load, and compares that sum with capacity.
// Check steps per stored trip: read trip i, latch its points and clear the
// accumulator, scan all n trips through the single read port of the trip
// store, then compare; after the last trip the result register is loaded.
// The input stays stalled during the check and opens again at the edge that
// loads the result register.
// The result (fits, too_many_trips) is one word on the out_ channel, held in
// an output register; new trips are taken while it waits. If out_stall holds
// the word and another set finishes, the block waits before overwriting it.
// cfg_we writes capacity; write it only while the block is idle.
// Reset (rst_n low, synchronous) empties the store and sets capacity to 0.
module interval_capacity_check_top
  import icc_pkg::*;
#(
  parameter int MAX_TRIPS  = MAX_TRIPS_DEF,
  parameter int POINT_BITS = POINT_BITS_DEF,
  parameter int LOAD_BITS  = LOAD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CAP_BITS-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LOAD_BITS-1:0]  in_load_count,
  input  logic [POINT_BITS-1:0] in_pickup_point,
  input  logic [POINT_BITS-1:0] in_dropoff_point,
  input  logic                  in_last_trip,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_fits,
  output logic                  out_too_many_trips
);

  localparam int AW = $clog2(MAX_TRIPS);
  localparam int NW = $clog2(MAX_TRIPS + 1);
  localparam int TW = LOAD_BITS + 2 * POINT_BITS;

  icc_state_t state_r, state_nxt;

  logic [CAP_BITS-1:0]   cap_r;
  logic [NW-1:0]         count_r, count_nxt;
  logic [NW-1:0]         i_r, i_nxt;
  logic [NW-1:0]         j_r, j_nxt;
  logic [NW-1:0]         dj_r, dj_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  fits_r, fits_nxt;
  logic [POINT_BITS-1:0] ip_r, ip_nxt;
  logic [POINT_BITS-1:0] id_r, id_nxt;
  logic                  out_valid_r, out_fits_r, out_tmt_r;

  logic                  in_acc, out_acc;
  logic                  ram_we;
  logic [AW-1:0]         raddr;
  logic [TW-1:0]         rdata;
  acc_ctl_t              ctl;
  logic                  over;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign ram_we  = in_acc && (count_r < NW'(MAX_TRIPS));

  icc_ram #(.WIDTH(TW), .DEPTH(MAX_TRIPS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_load_count, in_pickup_point, in_dropoff_point}),
    .raddr (raddr),
    .rdata (rdata)
  );

  icc_acc #(
    .MAX_TRIPS(MAX_TRIPS), .POINT_BITS(POINT_BITS), .LOAD_BITS(LOAD_BITS)
  ) u_acc (
    .clk       (clk),
    .ctl       (ctl),
    .i_idx     (i_r[AW-1:0]),
    .i_pickup  (ip_r),
    .i_dropoff (id_r),
    .j_idx     (dj_r[AW-1:0]),
    .j_load    (rdata[TW-1 -: LOAD_BITS]),
    .j_pickup  (rdata[2*POINT_BITS-1 -: POINT_BITS]),
    .j_dropoff (rdata[POINT_BITS-1:0]),
    .capacity  (cap_r),
    .over      (over)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: if (in_acc && in_last_trip) state_nxt = S_RDI;
      S_RDI:  state_nxt = S_GETI;
      S_GETI: state_nxt = S_SCAN;
      S_SCAN: if (dj_r == count_r - NW'(1)) state_nxt = S_CHK;
      S_CHK: begin
        if (i_r + NW'(1) == count_r) state_nxt = S_DONE;
        else                         state_nxt = S_RDI;
      end
      S_DONE: if (!out_valid_r || out_acc) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  // Outputs and counter updates.
  always_comb begin
    in_stall  = 1'b1;
    raddr     = j_r[AW-1:0];
    ctl       = '{clear: 1'b0, en: 1'b0};
    count_nxt = count_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    dj_nxt    = dj_r;
    ovf_nxt   = ovf_r;
    fits_nxt  = fits_r;
    ip_nxt    = ip_r;
    id_nxt    = id_r;
    case (state_r)
      S_LOAD: begin
        in_stall = 1'b0;
        if (in_acc) begin
          if (ram_we) count_nxt = count_r + NW'(1);
          else        ovf_nxt   = 1'b1;
        end
        i_nxt    = '0;
        fits_nxt = 1'b1;
      end
      S_RDI: begin
        raddr = i_r[AW-1:0];
      end
      S_GETI: begin
        ip_nxt    = rdata[2*POINT_BITS-1 -: POINT_BITS];
        id_nxt    = rdata[POINT_BITS-1:0];
        raddr     = '0;
        j_nxt     = NW'(1);
        dj_nxt    = '0;
        ctl.clear = 1'b1;
      end
      S_SCAN: begin
        ctl.en = 1'b1;
        j_nxt  = j_r + NW'(1);
        dj_nxt = dj_r + NW'(1);
      end
      S_CHK: begin
        if (over) fits_nxt = 1'b0;
        i_nxt = i_r + NW'(1);
      end
      S_DONE: begin
        if (!out_valid_r || out_acc) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cap_r       <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      if (cfg_we) cap_r <= cfg_data;
      if (state_r == S_DONE && (!out_valid_r || out_acc)) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    dj_r   <= dj_nxt;
    fits_r <= fits_nxt;
    ip_r   <= ip_nxt;
    id_r   <= id_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_acc)) begin
      out_fits_r <= fits_r;
      out_tmt_r  <= ovf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fits           = out_fits_r;
  assign out_too_many_trips = out_tmt_r;

  // The stored trip count never exceeds the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(MAX_TRIPS))
    else $error("trip count beyond store depth");

  // The scan only reads stored trips.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (dj_r < count_r))
    else $error("scan index beyond trip count");

  // A held result is never overwritten before it is taken.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_fits_r) &&
                                    $stable(out_tmt_r)))
    else $error("pending result lost");

  // Input is taken only while loading.
  a_stall_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> in_stall)
    else $error("input accepted while checking");

endmodule

@@ sim/interval_capacity_check_top_test.sv @@
// Self-checking testbench for the interval capacity check block.
module interval_capacity_check_top_test;
  import icc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TRIPS = MAX_TRIPS_DEF;
  localparam int LIMIT_CYCLES = 2000000;

  typedef struct {
    logic [LOAD_BITS_DEF-1:0]  load;
    logic [POINT_BITS_DEF-1:0] pickup;
    logic [POINT_BITS_DEF-1:0] dropoff;
  } trip_t;

  typedef struct {
    logic fits;
    logic too_many;
  } verdict_t;

  // The scoreboard keeps its own trip set and capacity, and computes the
  // verdict for a set when the word that closes it is accepted.
  class capacity_scoreboard;
    trip_t trips[$];
    logic overflow;
    logic [CAP_BITS-1:0] capacity;
    verdict_t pending[$];
    int errors;

    function new();
      overflow = 0;
      capacity = '0;
      errors = 0;
    endfunction

    // Sweep the points in order: at each pickup, trips already dropped off
    // at or before it are gone. Sorting then summing active loads matches a
    // min-queue release sweep.
    function logic judge();
      trip_t s[$];
      int occ;
      s = trips;
      s.sort() with ({item.pickup, item.dropoff});
      for (int i = 0; i < s.size(); i++) begin
        occ = s[i].load;
        for (int j = 0; j < i; j++)
          if (s[j].dropoff > s[i].pickup) occ += s[j].load;
        if (occ > capacity) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_trip(trip_t t, logic last);
      verdict_t v;
      if (trips.size() < MAX_TRIPS) trips.insert(trips.size(), t);
      else overflow = 1;
      if (last) begin
        v.fits = judge();
        v.too_many = overflow;
        pending.insert(pending.size(), v);
        trips.delete();
        overflow = 0;
      end
    endfunction

    function void check_verdict(logic fits, logic too_many);
      verdict_t v;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word fits=%0b too_many_trips=%0b", $realtime, fits,
                 too_many);
        errors++;
        return;
      end
      v = pending.pop_front();
      if (fits !== v.fits) begin
        $display("%0t: fits expected %0b actual %0b", $realtime, v.fits, fits);
        errors++;
      end
      if (too_many !== v.too_many) begin
        $display("%0t: too_many_trips expected %0b actual %0b", $realtime, v.too_many,
                 too_many);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CAP_BITS-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [LOAD_BITS_DEF-1:0] in_load_count = '0;
  logic [POINT_BITS_DEF-1:0] in_pickup_point = '0;
  logic [POINT_BITS_DEF-1:0] in_dropoff_point = '0;
  logic in_last_trip = 0;
  logic out_valid;
  logic out_stall = 0;
  logic out_fits;
  logic out_too_many_trips;

  capacity_scoreboard board = new();
  int cycle_count = 0;
  int stall_mode = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  interval_capacity_check_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_load_count(in_load_count),
    .in_pickup_point(in_pickup_point), .in_dropoff_point(in_dropoff_point),
    .in_last_trip(in_last_trip), .out_valid(out_valid), .out_stall(out_stall),
    .out_fits(out_fits), .out_too_many_trips(out_too_many_trips)
  );

  // Results are sampled at the rising edge, the same edge that accepts them.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall)
      board.check_verdict(out_fits, out_too_many_trips);
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The receiver stall follows a mode that the stimulus changes per phase:
  // never stalling, light random stalls, or heavy random stalls.
  always @(negedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 7) < 5);
    endcase
  end

  // Drive one word and hold it until the block accepts it. The sender
  // occasionally idles for a short gap before a word, so gaps land both in
  // loading and while the block is checking. Valid stays high after the
  // accept so the next word can follow back to back; end_burst drops it.
  task automatic send_trip(trip_t t, logic last, int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      for (int g = 0; g < gap; g++) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_load_count <= t.load;
    in_pickup_point <= t.pickup;
    in_dropoff_point <= t.dropoff;
    in_last_trip <= last;
    do @(posedge clk); while (in_stall);
    board.note_trip(t, last);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Sender gaps: bursts without gaps, then random short gaps.
  int burst_left = 0;
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 12);
    return $urandom_range(1, 5);
  endfunction

  function automatic trip_t random_trip(int span);
    trip_t t;
    t.load = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, 40));
    t.pickup = 10'($urandom_range(0, span));
    // Mostly well-formed intervals; some end before they start.
    if ($urandom_range(0, 9) == 0) t.dropoff = 10'($urandom_range(0, span));
    else t.dropoff = 10'(t.pickup + $urandom_range(0, span / 4 + 1));
    return t;
  endfunction

  // Capacity is only written once the previous set's verdict is back and the
  // block has had time to return to loading.
  task automatic set_capacity(logic [CAP_BITS-1:0] value);
    end_burst();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.capacity = value;
  endtask

  task automatic send_set(int n, int span);
    for (int i = 0; i < n; i++) send_trip(random_trip(span), i == n - 1, next_gap());
  endtask

  trip_t t;
  int sent;

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. With capacity zero, a zero load fits and any load fails.
    t = '{8'd0, 10'd0, 10'd1023};
    send_trip(t, 1, 0);
    t = '{8'd1, 10'd5, 10'd6};
    send_trip(t, 1, 0);
    set_capacity(16'd255);
    // Full load, extreme points; then a back-to-back pair that touches at a
    // point, where the release comes before the board.
    t = '{8'd255, 10'd1023, 10'd1023};
    send_trip(t, 1, 0);
    t = '{8'd255, 10'd0, 10'd512};
    send_trip(t, 0, 0);
    t = '{8'd255, 10'd512, 10'd1023};
    send_trip(t, 1, 0);
    // Overlapping pair exceeds the capacity.
    t = '{8'd200, 10'd10, 10'd20};
    send_trip(t, 0, 0);
    t = '{8'd100, 10'd15, 10'd30};
    send_trip(t, 1, 0);
    // Dropoff before pickup: boards, then leaves before the next trip.
    t = '{8'd200, 10'd100, 10'd50};
    send_trip(t, 0, 1);
    t = '{8'd200, 10'd101, 10'd300};
    send_trip(t, 1, 0);
    // Store full: one trip past the store is dropped and flagged.
    set_capacity(16'hFFFF);
    for (int i = 0; i <= MAX_TRIPS; i++) begin
      t = '{8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
            10'($urandom_range(0, 1023))};
      send_trip(t, i == MAX_TRIPS, 0);
    end
    // A set after the overflow starts clean.
    t = '{8'd3, 10'd682, 10'd341};
    send_trip(t, 1, 0);

    // Random part: sets of mostly small size with a capacity near typical
    // occupancy, so both verdicts appear; the capacity and stall pattern
    // change from phase to phase. The directed part already sent 75 words.
    sent = 75;
    while (sent < 550) begin
      int n;
      stall_mode = $urandom_range(0, 2);
      case ($urandom_range(0, 5))
        0: set_capacity(16'd0);
        1: set_capacity(16'hFFFF);
        default: set_capacity(16'($urandom_range(20, 300)));
      endcase
      for (int s = 0; s < 6 && sent < 550; s++) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
        send_set(n, $urandom_range(0, 3) == 0 ? 1023 : 63);
        sent += n;
      end
    end

    end_burst();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
src/icc_pkg.sv
src/icc_ram.sv
src/icc_acc.sv
src/interval_capacity_check_top.sv
sim/interval_capacity_check_top_test.sv
